// File: rtl/assert_macros.svh
// Assertion macros used by the sequencer RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Check a property on every rising clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assertion failed");
// Check an implication on every rising clock edge outside reset
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error("assertion failed");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_IMP(label, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/ufcl_pkg.sv
// Types and constants for the union-find component length filter
package ufcl_pkg;
  localparam int unsigned NODES   = 4096;
  localparam int unsigned IDX_W   = $clog2(NODES);
  localparam int unsigned ID_W    = 12;
  localparam int unsigned LEN_W   = 20;
  localparam int unsigned OVL_W   = 16;
  localparam int unsigned MIN_W   = 31;
  localparam int unsigned SUM_W   = 37;
  localparam int unsigned RANK_W  = 4;
  localparam int unsigned CFG_W   = 31;
  localparam int unsigned ENTRY_W = IDX_W + RANK_W + SUM_W;

  localparam logic [1:0] REQ_DECLARE = 2'd0;
  localparam logic [1:0] REQ_VISIT   = 2'd1;
  localparam logic [1:0] REQ_QUERY   = 2'd2;

  localparam logic CFG_MIN_LEN = 1'b0;
  localparam logic CFG_OVERLAP = 1'b1;

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
  localparam logic [RANK_W-1:0] RANK_MAX = '1;

  // One node entry: parent link, rank and root length
  typedef struct packed {
    logic [IDX_W-1:0]        parent;
    logic [RANK_W-1:0]       rank;
    logic signed [SUM_W-1:0] length;
  } entry_t;

  // Memory port between the sequencer and the node memory
  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;
  } mem_req_t;
endpackage

// File: rtl/ufcl_node_mem.sv
// Node memory: parent, rank and root length per node, one read and one write port
module ufcl_node_mem
  import ufcl_pkg::*;
(
  input  logic     clk_i,
  input  mem_req_t req_i,
  output entry_t   rd_data_o
);
  entry_t mem_q [NODES];

  // Write one entry and register one read
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_o <= mem_q[req_i.rd_addr];
    end
  end
endmodule

// File: rtl/ufcl_declared.sv
// Declared flags: one bit per node in a synchronous memory, cleared by a pass after reset
module ufcl_declared
  import ufcl_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             set_i,
  input  logic [IDX_W-1:0] set_idx_i,
  input  logic [IDX_W-1:0] rd_idx_i,
  output logic             rd_o,
  output logic             clearing_o
);
  logic             flag_q [NODES];
  logic             clearing_q;
  logic [IDX_W-1:0] clr_idx_q;

  // Step the clearing pass over every entry once after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_idx_q <= '0;
    end else if (clearing_q) begin
      clr_idx_q <= clr_idx_q + 1'b1;
      if (clr_idx_q == IDX_W'(NODES - 1)) clearing_q <= 1'b0;
    end
  end

  // Clear or set one flag and register one read
  always_ff @(posedge clk_i) begin
    if (clearing_q) begin
      flag_q[clr_idx_q] <= 1'b0;
    end else if (set_i) begin
      flag_q[set_idx_i] <= 1'b1;
    end
    rd_o <= flag_q[rd_idx_i];
  end

  assign clearing_o = clearing_q;
endmodule

// File: rtl/ufcl_seq.sv
// Sequencer: decodes requests, walks parent chains, merges and compresses
`include "assert_macros.svh"
module ufcl_seq
  import ufcl_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic               clearing_i,
  input  logic [1:0]         req_type_i,
  input  logic [ID_W-1:0]    node_id_i,
  input  logic [LEN_W-1:0]   node_length_i,
  input  logic               starts_path_i,
  input  logic [MIN_W-1:0]   min_len_i,
  input  logic [OVL_W-1:0]   overlap_i,
  output mem_req_t           mem_o,
  input  entry_t             rd_data_i,
  output logic [IDX_W-1:0]   decl_idx_o,
  input  logic               decl_i,
  output logic               decl_set_o,
  output logic               res_valid_o,
  output logic [ID_W-1:0]    queried_node_o,
  output logic [ID_W-1:0]    root_node_o,
  output logic [SUM_W-1:0]   component_length_o,
  output logic               is_long_o,
  output logic               is_known_o
);
  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_FIND_RD, S_FIND_WT, S_COMP_RD, S_COMP_WT,
    S_ROOTA_RD, S_ROOTA_WT, S_ROOTB_RD, S_ROOTB_WT, S_LINK
  } state_e;

  state_e            state_q;
  logic [1:0]        kind_q;
  logic [IDX_W-1:0]  id_q, prev_q, cur_q, start_q, root_q, ra_q;
  logic              have_prev_q, second_q, starts_q;
  logic [LEN_W-1:0]  len_q;
  entry_t            ea_q;
  logic [IDX_W-1:0]  hops_q;

  logic [IDX_W-1:0] in_idx;
  assign in_idx = IDX_W'(node_id_i);
  assign decl_idx_o = (state_q == S_IDLE) ? in_idx : id_q;
  assign busy_o = (state_q != S_IDLE) || clearing_i;

  // Saturating merge of two root lengths
  logic signed [SUM_W:0]   sum_wide;
  logic signed [SUM_W-1:0] sum_sat;
  assign sum_wide = {ea_q.length[SUM_W-1], ea_q.length}
                  + {rd_data_i.length[SUM_W-1], rd_data_i.length};
  always_comb begin
    if (sum_wide > $signed({SUM_MAX[SUM_W-1], SUM_MAX})) sum_sat = SUM_MAX;
    else if (sum_wide < $signed({SUM_MIN[SUM_W-1], SUM_MIN})) sum_sat = SUM_MIN;
    else sum_sat = sum_wide[SUM_W-1:0];
  end

  logic signed [SUM_W-1:0] decl_len;
  assign decl_len = $signed({{(SUM_W-LEN_W){1'b0}}, len_q})
                  - $signed({{(SUM_W-OVL_W){1'b0}}, overlap_i});

  // Memory requests
  always_comb begin
    mem_o = '0;
    decl_set_o = 1'b0;
    case (state_q)
      S_DECODE: begin
        if (kind_q == REQ_DECLARE && !decl_i) begin
          decl_set_o = 1'b1;
          mem_o.wr_en = 1'b1;
          mem_o.wr_addr = id_q;
          mem_o.wr_data = '{parent: id_q, rank: '0, length: decl_len};
        end
      end
      S_FIND_RD, S_COMP_RD: begin
        mem_o.rd_en = 1'b1;
        mem_o.rd_addr = cur_q;
      end
      S_COMP_WT: begin
        if (cur_q != root_q) begin
          mem_o.wr_en = 1'b1;
          mem_o.wr_addr = cur_q;
          mem_o.wr_data = '{parent: root_q, rank: rd_data_i.rank,
                            length: rd_data_i.length};
        end
      end
      S_ROOTA_RD: begin
        mem_o.rd_en = 1'b1;
        mem_o.rd_addr = ra_q;
      end
      S_ROOTB_RD: begin
        mem_o.rd_en = 1'b1;
        mem_o.rd_addr = root_q;
      end
      S_ROOTB_WT: begin
        // link lower-rank root below the other
        mem_o.wr_en = 1'b1;
        if (ea_q.rank < rd_data_i.rank) begin
          mem_o.wr_addr = ra_q;
          mem_o.wr_data = '{parent: root_q, rank: ea_q.rank, length: ea_q.length};
        end else begin
          mem_o.wr_addr = root_q;
          mem_o.wr_data = '{parent: ra_q, rank: rd_data_i.rank,
                            length: rd_data_i.length};
        end
      end
      S_LINK: begin
        mem_o.wr_en = 1'b1;
        mem_o.wr_addr = root_q;
        mem_o.wr_data = ea_q;
      end
      default: ;
    endcase
  end

  // Hold state and registered results
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      have_prev_q <= 1'b0;
      prev_q <= '0;
      res_valid_o <= 1'b0;
      kind_q <= '0; id_q <= '0; cur_q <= '0; start_q <= '0; root_q <= '0;
      ra_q <= '0; second_q <= 1'b0; ea_q <= '0; hops_q <= '0;
      starts_q <= 1'b0; len_q <= '0;
      queried_node_o <= '0; root_node_o <= '0; component_length_o <= '0;
      is_long_o <= 1'b0; is_known_o <= 1'b0;
    end else begin
      res_valid_o <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start_i && !clearing_i) begin
            kind_q <= req_type_i;
            id_q <= in_idx;
            cur_q <= in_idx;
            start_q <= in_idx;
            len_q <= node_length_i;
            starts_q <= starts_path_i;
            hops_q <= '0;
            second_q <= 1'b0;
            state_q <= S_DECODE;
          end
        end
        S_DECODE: begin
          // act on the declared flag read at accept
          state_q <= S_IDLE;
          case (kind_q)
            REQ_VISIT: begin
              if (!decl_i) begin
                if (starts_q) have_prev_q <= 1'b0;
              end else if (!starts_q && have_prev_q) begin
                cur_q <= prev_q; start_q <= prev_q;
                prev_q <= id_q;
                state_q <= S_FIND_RD;
              end else begin
                prev_q <= id_q;
                have_prev_q <= 1'b1;
              end
            end
            REQ_QUERY: begin
              if (decl_i) begin
                state_q <= S_FIND_RD;
              end else begin
                res_valid_o <= 1'b1;
                queried_node_o <= ID_W'(id_q);
                root_node_o <= ID_W'(id_q);
                component_length_o <= '0;
                is_long_o <= 1'b0;
                is_known_o <= 1'b0;
              end
            end
            default: ;
          endcase
        end
        S_FIND_RD: state_q <= S_FIND_WT;
        S_FIND_WT: begin
          // advance along the parent chain
          if (rd_data_i.parent == cur_q || hops_q == IDX_W'(NODES - 1)) begin
            root_q <= cur_q;
            cur_q <= start_q;
            hops_q <= '0;
            state_q <= S_COMP_RD;
          end else begin
            cur_q <= rd_data_i.parent;
            hops_q <= hops_q + 1'b1;
            state_q <= S_FIND_RD;
          end
        end
        S_COMP_RD: state_q <= S_COMP_WT;
        S_COMP_WT: begin
          if (cur_q != root_q) begin
            cur_q <= rd_data_i.parent;
            state_q <= S_COMP_RD;
          end else if (kind_q == REQ_QUERY) begin
            res_valid_o <= 1'b1;
            queried_node_o <= ID_W'(id_q);
            root_node_o <= ID_W'(root_q);
            component_length_o <= rd_data_i.length;
            is_long_o <= rd_data_i.length >= $signed({6'b0, min_len_i});
            is_known_o <= 1'b1;
            state_q <= S_IDLE;
          end else if (!second_q) begin
            second_q <= 1'b1;
            ra_q <= root_q;
            cur_q <= id_q;
            start_q <= id_q;
            state_q <= S_FIND_RD;
          end else if (ra_q == root_q) begin
            state_q <= S_IDLE;
          end else begin
            state_q <= S_ROOTA_RD;
          end
        end
        S_ROOTA_RD: state_q <= S_ROOTA_WT;
        S_ROOTA_WT: begin
          ea_q <= rd_data_i;
          state_q <= S_ROOTB_RD;
        end
        S_ROOTB_RD: state_q <= S_ROOTB_WT;
        S_ROOTB_WT: begin
          // survivor gets the summed length and maybe a bumped rank
          if (ea_q.rank < rd_data_i.rank) begin
            ea_q <= '{parent: root_q, rank: rd_data_i.rank, length: sum_sat};
          end else begin
            root_q <= ra_q;
            ea_q <= '{parent: ra_q,
                      rank: (ea_q.rank == rd_data_i.rank && ea_q.rank != RANK_MAX)
                            ? ea_q.rank + 1'b1 : ea_q.rank,
                      length: sum_sat};
          end
          state_q <= S_LINK;
        end
        S_LINK: state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `ASSERT_IMP(a_no_rw_idle, clk_i, rst_ni, state_q == S_IDLE, !mem_o.rd_en)
  `ASSERT_IMP(a_res_one, clk_i, rst_ni, res_valid_o, $past(busy_o) || $past(start_i))
  `ASSERT_IMP(a_link_diff, clk_i, rst_ni, state_q == S_ROOTB_WT, ra_q != root_q)
endmodule

// File: rtl/union_find_component_length_filter_core.sv
// Top level of the union-find component length filter
// A query walks the parent chain of the node and compresses it before the result shows;
// an undeclared query answers from the decode state. Declare and plain visits end after decode.
// One request at a time: busy holds while a query or a merge walks, and a merge walks both ends
// and skips the link when both ends share a root; depths at most 12 under union by rank.
// Reset clears traversal state and registers, then busy holds for a pass that clears the
// declared flags; node memory is not cleared. Results cannot be stalled.
module union_find_component_length_filter_core
  import ufcl_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         req_type_i,
  input  logic [ID_W-1:0]    node_id_i,
  input  logic [LEN_W-1:0]   node_length_i,
  input  logic               starts_path_i,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [CFG_W-1:0]   cfg_data_i,
  output logic               result_valid_o,
  output logic [ID_W-1:0]    queried_node_o,
  output logic [ID_W-1:0]    root_node_o,
  output logic [SUM_W-1:0]   component_length_o,
  output logic               is_long_o,
  output logic               is_known_o
);
  logic [MIN_W-1:0] min_len_q;
  logic [OVL_W-1:0] overlap_q;
  mem_req_t         mem_req;
  entry_t           rd_data;
  logic [IDX_W-1:0] decl_idx;
  logic             decl, decl_set, clearing;

  // Hold configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_len_q <= '0;
      overlap_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MIN_LEN: min_len_q <= cfg_data_i[MIN_W-1:0];
        CFG_OVERLAP: overlap_q <= cfg_data_i[OVL_W-1:0];
        default: ;
      endcase
    end
  end

  ufcl_node_mem u_mem (.clk_i, .req_i(mem_req), .rd_data_o(rd_data));

  ufcl_declared u_decl (
    .clk_i, .rst_ni, .set_i(decl_set), .set_idx_i(decl_idx),
    .rd_idx_i(decl_idx), .rd_o(decl), .clearing_o(clearing)
  );

  ufcl_seq u_seq (
    .clk_i, .rst_ni, .start_i(start), .busy_o(busy), .clearing_i(clearing),
    .req_type_i, .node_id_i, .node_length_i, .starts_path_i,
    .min_len_i(min_len_q), .overlap_i(overlap_q),
    .mem_o(mem_req), .rd_data_i(rd_data),
    .decl_idx_o(decl_idx), .decl_i(decl), .decl_set_o(decl_set),
    .res_valid_o(result_valid_o), .queried_node_o, .root_node_o,
    .component_length_o, .is_long_o, .is_known_o
  );
endmodule
